/* hw/rtl/balance_velocity_drive_controller_top_macros.svh */
// Assertion macros shared by the controller modules.
`ifndef BALANCE_VELOCITY_DRIVE_CONTROLLER_TOP_MACROS_SVH
`define BALANCE_VELOCITY_DRIVE_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication.
`define BVDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("property violated");

// Next-cycle implication.
`define BVDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("property violated");

`endif

/* hw/rtl/bvdc_pkg.sv */
package bvdc_pkg;

  localparam int ANGLE_W   = 17;
  localparam int GYRO_W    = 16;
  localparam int COUNT_W   = 16;
  localparam int GAIN_W    = 24;
  localparam int ILIM_W    = 20;
  localparam int DLIM_W    = 15;
  localparam int DRIVE_W   = 16;
  localparam int DIFF_W    = ANGLE_W + 1;
  localparam int SPD_W     = COUNT_W + 1;
  localparam int FILT_W    = 26;
  localparam int INTEG_W   = 32;
  localparam int ISUM_W    = INTEG_W + 1;
  localparam int FRAC_B    = 8;
  localparam int ILIM256_W = ILIM_W + FRAC_B + 1;
  localparam int VSUM_W    = 28;
  localparam int NMAG_W    = VSUM_W - 1;
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 29;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 54;
  localparam int FRAC_W    = 16;
  localparam int TERM_W    = ACC_W - FRAC_W;
  localparam int TOTAL_W   = TERM_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = GAIN_W;
  localparam int PC_W      = 4;

  // floor(2^30 / 5); quotient off by at most one for magnitudes below 2^27
  localparam int RECIP5_SHIFT = 30;
  localparam int RECIP5_W     = 28;
  localparam logic [RECIP5_W-1:0] RECIP5 = RECIP5_W'(214748364);
  localparam int QUOT_W       = 25;
  localparam logic [NMAG_W-1:0] DIV5 = NMAG_W'(5);

  localparam logic signed [ANGLE_W-1:0] MIDDLE_RST = ANGLE_W'(0);
  localparam logic signed [GAIN_W-1:0]  KP_RST     = GAIN_W'(122880);
  localparam logic signed [GAIN_W-1:0]  KD_RST     = GAIN_W'(768);
  localparam logic signed [GAIN_W-1:0]  VKP_RST    = GAIN_W'(-76800);
  localparam logic signed [GAIN_W-1:0]  VKI_RST    = GAIN_W'(-256);
  localparam logic [ILIM_W-1:0]         ILIM_RST   = ILIM_W'(12000);
  localparam logic [DLIM_W-1:0]         DLIM_RST   = DLIM_W'(7200);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIDDLE_ANGLE   = 3'd0,
    REG_BALANCE_GAIN_P = 3'd1,
    REG_BALANCE_GAIN_D = 3'd2,
    REG_SPEED_GAIN_P   = 3'd3,
    REG_SPEED_GAIN_I   = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5,
    REG_DRIVE_LIMIT    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] middle;
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  kd;
    logic signed [GAIN_W-1:0]  vkp;
    logic signed [GAIN_W-1:0]  vki;
    logic [ILIM_W-1:0]         ilim;
    logic [DLIM_W-1:0]         dlim;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE    = 3'd0,
    MUL_KP_DIFF = 3'd1,
    MUL_KD_GYRO = 3'd2,
    MUL_N_RECIP = 3'd3,
    MUL_F_VKP   = 3'd4,
    MUL_I_VKI   = 3'd5
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD     = 2'd0,
    ACC_LOAD     = 2'd1,
    ACC_ADD      = 2'd2,
    ACC_ADD_SHL8 = 2'd3
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NONE      = 2'd0,
    COND_WAIT_ITEM = 2'd1,
    COND_WAIT_OUT  = 2'd2
  } cond_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    logic     cap;
    logic     n_ld;
    logic     bal_ld;
    logic     q_ld;
    logic     f_ld;
    logic     i_ld;
    logic     vel_ld;
    logic     out_ld;
  } ctl_t;

  typedef struct packed {
    cond_t cond;
    logic  ret;
    ctl_t  ctl;
  } uword_t;

  typedef struct packed {
    logic item;
    logic out_busy;
  } stat_t;

  localparam logic [PC_W-1:0] STEP_CAPTURE = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_DIFF    = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_GYRO    = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_RECIP   = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_BAL     = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_FILT    = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_INTEG   = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_VKI     = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_VACC    = PC_W'(8);
  localparam logic [PC_W-1:0] STEP_VEL     = PC_W'(9);
  localparam logic [PC_W-1:0] STEP_OUT     = PC_W'(10);

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    case (pc)
      STEP_CAPTURE: begin
        w.cond    = COND_WAIT_ITEM;
        w.ctl.cap = 1'b1;
      end
      STEP_DIFF: begin
        w.ctl.mul  = MUL_KP_DIFF;
        w.ctl.n_ld = 1'b1;
      end
      STEP_GYRO: begin
        w.ctl.mul = MUL_KD_GYRO;
        w.ctl.acc = ACC_LOAD;
      end
      STEP_RECIP: begin
        w.ctl.mul = MUL_N_RECIP;
        w.ctl.acc = ACC_ADD_SHL8;
      end
      STEP_BAL: begin
        w.ctl.bal_ld = 1'b1;
        w.ctl.q_ld   = 1'b1;
      end
      STEP_FILT: begin
        w.ctl.f_ld = 1'b1;
      end
      STEP_INTEG: begin
        w.ctl.i_ld = 1'b1;
        w.ctl.mul  = MUL_F_VKP;
      end
      STEP_VKI: begin
        w.ctl.mul = MUL_I_VKI;
        w.ctl.acc = ACC_LOAD;
      end
      STEP_VACC: begin
        w.ctl.acc = ACC_ADD;
      end
      STEP_VEL: begin
        w.ctl.vel_ld = 1'b1;
      end
      STEP_OUT: begin
        w.cond       = COND_WAIT_OUT;
        w.ctl.out_ld = 1'b1;
        w.ret        = 1'b1;
      end
      default: begin
        w.ret = 1'b1;
      end
    endcase
    return w;
  endfunction

  // divide by 2^16, rounding toward zero
  function automatic logic signed [TERM_W-1:0] trunc_frac(input logic signed [ACC_W-1:0] a);
    logic signed [TERM_W-1:0] t;
    t = TERM_W'(a >>> FRAC_W);
    if (a[ACC_W-1] && (a[FRAC_W-1:0] != '0)) begin
      t = t + TERM_W'(1);
    end
    return t;
  endfunction

endpackage

/* hw/rtl/balance_velocity_drive_controller_top.sv */
// Balance and velocity drive controller for a two-wheel balancing platform.
// Input channel (in_valid / in_stall): one transfer per control tick carrying
// roll_angle, gyro_rate, wheel_count_left and wheel_count_right.
// Output channel (out_valid / out_stall): one transfer per input carrying the
// drive value for both motors and the saturated flag.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): write
// the gains and limits while no item is in flight; cfg_ready is always high.
// The microcode program steps one shared 32 x 29 multiplier through the four
// products and the reciprocal divide of the speed filter; a new item is taken
// only after the result of the previous item is loaded into the output
// register.
// in_stall is low only while the sequencer waits on its first step.
// A stalled result holds in the output register while the next item is
// taken; the last step waits there until that register frees up.
// Reset restores the default gains and limits and clears the speed filter,
// the speed integral and the output valid flag.
module balance_velocity_drive_controller_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bvdc_pkg::ANGLE_W-1:0] roll_angle,
  input  logic signed [bvdc_pkg::GYRO_W-1:0]  gyro_rate,
  input  logic signed [bvdc_pkg::COUNT_W-1:0] wheel_count_left,
  input  logic signed [bvdc_pkg::COUNT_W-1:0] wheel_count_right,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bvdc_pkg::DRIVE_W-1:0] drive,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bvdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bvdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bvdc_pkg::*;

  cfg_t  cfg;
  ctl_t  ctl;
  stat_t stat;
  logic  idle;
  logic  out_busy;

  assign stat.item     = in_valid;
  assign stat.out_busy = out_busy;
  assign in_stall      = !idle;

  bvdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bvdc_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl),
    .idle (idle)
  );

  bvdc_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .cfg               (cfg),
    .roll_angle        (roll_angle),
    .gyro_rate         (gyro_rate),
    .wheel_count_left  (wheel_count_left),
    .wheel_count_right (wheel_count_right),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .drive             (drive),
    .saturated         (saturated),
    .out_busy          (out_busy)
  );

endmodule

/* hw/rtl/bvdc_cfg.sv */
module bvdc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bvdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bvdc_pkg::CFG_DATA_W-1:0] cfg_data,
  output bvdc_pkg::cfg_t                 cfg
);
  import bvdc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.middle <= MIDDLE_RST;
      cfg.kp     <= KP_RST;
      cfg.kd     <= KD_RST;
      cfg.vkp    <= VKP_RST;
      cfg.vki    <= VKI_RST;
      cfg.ilim   <= ILIM_RST;
      cfg.dlim   <= DLIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIDDLE_ANGLE:   cfg.middle <= cfg_data[ANGLE_W-1:0];
        REG_BALANCE_GAIN_P: cfg.kp     <= cfg_data[GAIN_W-1:0];
        REG_BALANCE_GAIN_D: cfg.kd     <= cfg_data[GAIN_W-1:0];
        REG_SPEED_GAIN_P:   cfg.vkp    <= cfg_data[GAIN_W-1:0];
        REG_SPEED_GAIN_I:   cfg.vki    <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg.ilim   <= cfg_data[ILIM_W-1:0];
        REG_DRIVE_LIMIT:    cfg.dlim   <= cfg_data[DLIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/bvdc_sequencer.sv */
`include "balance_velocity_drive_controller_top_macros.svh"

module bvdc_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  bvdc_pkg::stat_t stat,
  output bvdc_pkg::ctl_t  ctl,
  output logic            idle
);
  import bvdc_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          w;
  logic            go;

  always_comb begin
    w  = ucode(pc);
    go = !(((w.cond == COND_WAIT_ITEM) && !stat.item) ||
           ((w.cond == COND_WAIT_OUT) && stat.out_busy));
    if (!go) begin
      pc_next = pc;
    end else if (w.ret) begin
      pc_next = STEP_CAPTURE;
    end else begin
      pc_next = pc + PC_W'(1);
    end
    if (go) begin
      ctl = w.ctl;
    end else begin
      ctl = '0;
    end
  end

  assign idle = (pc == STEP_CAPTURE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_CAPTURE;
    end else begin
      pc <= pc_next;
    end
  end

  `BVDC_ASSERT_IMPL(a_out_ld_free, clk, rst, ctl.out_ld, !stat.out_busy)
  `BVDC_ASSERT_NEXT(a_cap_busy, clk, rst, ctl.cap, !idle)
  `BVDC_ASSERT_NEXT(a_out_ld_return, clk, rst, ctl.out_ld, idle)

endmodule

/* hw/rtl/bvdc_datapath.sv */
`include "balance_velocity_drive_controller_top_macros.svh"

module bvdc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  bvdc_pkg::ctl_t                      ctl,
  input  bvdc_pkg::cfg_t                      cfg,
  input  logic signed [bvdc_pkg::ANGLE_W-1:0] roll_angle,
  input  logic signed [bvdc_pkg::GYRO_W-1:0]  gyro_rate,
  input  logic signed [bvdc_pkg::COUNT_W-1:0] wheel_count_left,
  input  logic signed [bvdc_pkg::COUNT_W-1:0] wheel_count_right,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [bvdc_pkg::DRIVE_W-1:0] drive,
  output logic                                saturated,
  output logic                                out_busy
);
  import bvdc_pkg::*;

  logic signed [ANGLE_W-1:0]   angle_q;
  logic signed [GYRO_W-1:0]    gyro_q;
  logic signed [COUNT_W-1:0]   left_q;
  logic signed [COUNT_W-1:0]   right_q;
  logic [NMAG_W-1:0]           n;
  logic                        nsign;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;
  logic [QUOT_W-1:0]           q;
  logic signed [TERM_W-1:0]    bal;
  logic signed [TERM_W-1:0]    vel;
  logic signed [FILT_W-1:0]    filt;
  logic signed [INTEG_W-1:0]   integ;

  logic signed [DIFF_W-1:0]    diff;
  logic signed [SPD_W-1:0]     spd;
  logic signed [VSUM_W-1:0]    vsum;
  logic [NMAG_W-1:0]           n_next;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic [NMAG_W-1:0]           rem;
  logic [QUOT_W-1:0]           q1;
  logic signed [FILT_W-1:0]    filt_next;
  logic signed [ILIM256_W-1:0] ilim256;
  logic signed [ISUM_W-1:0]    isum;
  logic signed [INTEG_W-1:0]   integ_next;
  logic signed [TOTAL_W-1:0]   total;
  logic signed [TOTAL_W-1:0]   dlim_s;
  logic signed [DRIVE_W-1:0]   drive_next;
  logic                        saturated_next;

  always_comb begin
    diff   = DIFF_W'(angle_q) - DIFF_W'(cfg.middle);
    spd    = SPD_W'(left_q) + SPD_W'(right_q);
    vsum   = (VSUM_W'(filt) <<< 2) + (VSUM_W'(spd) <<< FRAC_B);
    n_next = NMAG_W'(vsum[VSUM_W-1] ? -vsum : vsum);

    case (ctl.mul)
      MUL_KP_DIFF: begin
        mul_a = MUL_A_W'(cfg.kp);
        mul_b = MUL_B_W'(diff);
      end
      MUL_KD_GYRO: begin
        mul_a = MUL_A_W'(cfg.kd);
        mul_b = MUL_B_W'(gyro_q);
      end
      MUL_N_RECIP: begin
        mul_a = MUL_A_W'({1'b0, n});
        mul_b = MUL_B_W'({1'b0, RECIP5});
      end
      MUL_F_VKP: begin
        mul_a = MUL_A_W'(filt);
        mul_b = MUL_B_W'(cfg.vkp);
      end
      MUL_I_VKI: begin
        mul_a = MUL_A_W'(integ);
        mul_b = MUL_B_W'(cfg.vki);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    rem       = n - (NMAG_W'(q) << 2) - NMAG_W'(q);
    q1        = q + QUOT_W'(rem >= DIV5);
    filt_next = nsign ? -FILT_W'(q1) : FILT_W'(q1);

    ilim256 = $signed({1'b0, cfg.ilim, FRAC_B'(0)});
    isum    = ISUM_W'(integ) + ISUM_W'(filt);
    if (isum > ISUM_W'(ilim256)) begin
      integ_next = INTEG_W'(ilim256);
    end else if (isum < -ISUM_W'(ilim256)) begin
      integ_next = -INTEG_W'(ilim256);
    end else begin
      integ_next = INTEG_W'(isum);
    end

    total  = TOTAL_W'(bal) + TOTAL_W'(vel);
    dlim_s = TOTAL_W'($signed({1'b0, cfg.dlim}));
    if (total > dlim_s) begin
      drive_next     = DRIVE_W'(dlim_s);
      saturated_next = 1'b1;
    end else if (total < -dlim_s) begin
      drive_next     = DRIVE_W'(-dlim_s);
      saturated_next = 1'b1;
    end else begin
      drive_next     = DRIVE_W'(total);
      saturated_next = 1'b0;
    end
  end

  assign out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      angle_q <= roll_angle;
      gyro_q  <= gyro_rate;
      left_q  <= wheel_count_left;
      right_q <= wheel_count_right;
    end
    if (ctl.n_ld) begin
      n     <= n_next;
      nsign <= vsum[VSUM_W-1];
    end
    prod <= mul_a * mul_b;
    case (ctl.acc)
      ACC_LOAD:     acc <= ACC_W'(prod);
      ACC_ADD:      acc <= acc + ACC_W'(prod);
      ACC_ADD_SHL8: acc <= acc + (ACC_W'(prod) <<< FRAC_B);
      default:      acc <= acc;
    endcase
    if (ctl.q_ld) begin
      q <= prod[RECIP5_SHIFT +: QUOT_W];
    end
    if (ctl.bal_ld) begin
      bal <= trunc_frac(acc);
    end
    if (ctl.vel_ld) begin
      vel <= trunc_frac(acc);
    end
    if (ctl.out_ld) begin
      drive     <= drive_next;
      saturated <= saturated_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt      <= '0;
      integ     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.f_ld) begin
        filt <= filt_next;
      end
      if (ctl.i_ld) begin
        integ <= integ_next;
      end
      if (ctl.out_ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BVDC_ASSERT_IMPL(a_rem_bound, clk, rst, ctl.f_ld, rem < (DIV5 << 1))
  `BVDC_ASSERT_NEXT(a_integ_clamp, clk, rst, ctl.i_ld, (integ <= INTEG_W'($past(ilim256))) && (integ >= -INTEG_W'($past(ilim256))))
  `BVDC_ASSERT_IMPL(a_valid_from_load, clk, rst, $rose(out_valid), $past(ctl.out_ld))

endmodule
